/* src/assert_macros.svh */
// Assertion helpers used by the RTL. Both expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define HBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define HBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/hbs_pkg.sv */
package hbs_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_DEPTH  = 256;
	localparam int STORE_SIZE = MAX_WIDTH * MAX_DEPTH;
	localparam int ADDR_W     = $clog2(STORE_SIZE);

	// grid coordinate integer parts
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int ZW = $clog2(MAX_DEPTH);

	// field widths fixed by the interface
	localparam int DIM_W    = 9;
	localparam int SCALE_W  = 24;
	localparam int IDX_W    = 16;
	localparam int HGT_W    = 8;
	localparam int POS_W    = 24;
	localparam int RES_W    = 16;
	localparam int IN_DW    = IDX_W + HGT_W + 2 * POS_W;
	localparam int CFG_IW   = 2;
	localparam int PROD_W   = 2 * (POS_W + 1);
	localparam int GRID_W   = PROD_W - 16;
	localparam int FRAC_W   = 8;

	localparam logic [DIM_W-1:0]   DIM_RST   = 9'd256;
	localparam logic [SCALE_W-1:0] SCALE_RST = 24'd32768;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_GRID_WIDTH = 2'd0,
		REG_GRID_DEPTH = 2'd1,
		REG_INV_SCALE  = 2'd2
	} cfg_reg_t;

	// 256 - frac, as a 9-bit weight
	function automatic logic [FRAC_W:0] inv_weight(input logic [FRAC_W-1:0] f);
		return (FRAC_W+1)'(1 << FRAC_W) - {1'b0, f};
	endfunction

endpackage

/* src/hbs_ram.sv */
module hbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

/* src/heightmap_bilinear_sample.sv */
// Bilinear heightmap sampler. Takes one item per clock when not stalled: a load writes
// one height byte, a query returns the bilinearly blended Q8.8 height (or zero with
// in_range low); loads return nothing. The height store is held twice, each copy with
// two read ports, so all four corners are fetched in the same cycle; loads write the
// store in the same pipeline slot where queries read it, so items see the store
// exactly in arrival order. The store is not cleared at reset. A stalled output backs
// up the pipeline stage by stage; bubbles ahead of it still close up.
module heightmap_bilinear_sample (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// load_index, load_height, query_x, query_z
	input  logic [hbs_pkg::IN_DW-1:0]   s_axis_tdata,
	// op
	input  logic [0:0]                  s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// height
	output logic [hbs_pkg::RES_W-1:0]   m_axis_tdata,
	// in_range
	output logic [0:0]                  m_axis_tuser,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [hbs_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [hbs_pkg::SCALE_W-1:0] cfg_data
);
	import hbs_pkg::*;

	`include "assert_macros.svh"

	localparam int BASE_W = ZW + DIM_W + 1;

	// configuration
	logic [DIM_W-1:0]   grid_width_q;
	logic [DIM_W-1:0]   grid_depth_q;
	logic [SCALE_W-1:0] inv_scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= DIM_RST;
			grid_depth_q <= DIM_RST;
			inv_scale_q  <= SCALE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GRID_WIDTH: grid_width_q <= cfg_data[DIM_W-1:0];
				REG_GRID_DEPTH: grid_depth_q <= cfg_data[DIM_W-1:0];
				REG_INV_SCALE:  inv_scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [DIM_W-1:0] w_cl, d_cl;
	assign w_cl = (32'(grid_width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : grid_width_q;
	assign d_cl = (32'(grid_depth_q) > MAX_DEPTH) ? DIM_W'(MAX_DEPTH) : grid_depth_q;

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

	assign rdy_out       = !out_valid_q || m_axis_tready;
	assign rdy5          = !v_s5 || rdy_out;
	assign rdy4          = !v_s4 || rdy5;
	assign rdy3          = !v_s3 || rdy4;
	assign rdy2          = !v_s2 || rdy3;
	assign rdy1          = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	// input unpack
	op_t                    in_op;
	logic [IDX_W-1:0]       in_idx;
	logic [HGT_W-1:0]       in_hgt;
	logic signed [POS_W-1:0] in_x, in_z;

	assign in_op  = op_t'(s_axis_tuser[0]);
	assign in_idx = s_axis_tdata[IDX_W-1:0];
	assign in_hgt = s_axis_tdata[IDX_W +: HGT_W];
	assign in_x   = s_axis_tdata[IDX_W+HGT_W +: POS_W];
	assign in_z   = s_axis_tdata[IDX_W+HGT_W+POS_W +: POS_W];

	// stage 1: world to scaled products
	op_t                      op_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [HGT_W-1:0]         hgt_s1;
	logic signed [PROD_W-1:0] px_s1, pz_s1;
	logic signed [POS_W:0]    neg_z;
	logic signed [POS_W:0]    scale_s;

	assign neg_z   = -(POS_W+1)'(in_z);
	assign scale_s = $signed({1'b0, inv_scale_q});

	// stage 2: grid coordinates and range check
	op_t              op_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [HGT_W-1:0] hgt_s2;
	logic             ok_s2;
	logic [XW-1:0]    x0_s2;
	logic [ZW-1:0]    z0_s2;
	logic [FRAC_W-1:0] fx_s2, fz_s2;
	logic [GRID_W-1:0] gx, gz, limx, limz;
	logic              ok_c;

	assign gx   = px_s1[PROD_W-1:16];
	assign gz   = pz_s1[PROD_W-1:16];
	assign limx = (w_cl != '0) ? GRID_W'(w_cl - DIM_W'(1)) << FRAC_W : '0;
	assign limz = (d_cl != '0) ? GRID_W'(d_cl - DIM_W'(1)) << FRAC_W : '0;
	// a negative product shows as the top bit of the grid value
	assign ok_c = !px_s1[PROD_W-1] && !pz_s1[PROD_W-1] && (gx < limx) && (gz < limz);

	// stage 3: corner addresses, store access
	op_t               op_s3;
	logic [IDX_W-1:0]  idx_s3;
	logic [HGT_W-1:0]  hgt_s3;
	logic              ok_s3;
	logic [XW-1:0]     x0_s3;
	logic [ZW-1:0]     z0_s3;
	logic [FRAC_W-1:0] fx_s3, fz_s3;
	logic [BASE_W-1:0] base, w_ext;
	logic [ADDR_W-1:0] a00, a01, a10, a11, waddr;
	logic              ram_we, ram_re;

	assign w_ext  = BASE_W'(w_cl);
	assign base   = BASE_W'(x0_s3) + BASE_W'(z0_s3) * w_ext;
	// in range, base + w + 1 stays below w * d, so no wrap occurs
	assign a00    = ADDR_W'(base);
	assign a01    = ADDR_W'(base + BASE_W'(1));
	assign a10    = ADDR_W'(base + w_ext);
	assign a11    = ADDR_W'(base + w_ext + BASE_W'(1));
	assign waddr  = ADDR_W'(idx_s3);
	assign ram_re = v_s3 && rdy4 && (op_s3 == OP_QUERY);
	assign ram_we = v_s3 && rdy4 && (op_s3 == OP_LOAD) && (32'(idx_s3) < STORE_SIZE);

	logic [HGT_W-1:0] h00, h01, h10, h11;

	hbs_ram #(.WIDTH(HGT_W), .DEPTH(STORE_SIZE)) u_ram_near (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (waddr),
		.wdata   (hgt_s3),
		.re      (ram_re),
		.raddr_a (a00),
		.raddr_b (a01),
		.rdata_a (h00),
		.rdata_b (h01)
	);

	hbs_ram #(.WIDTH(HGT_W), .DEPTH(STORE_SIZE)) u_ram_far (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (waddr),
		.wdata   (hgt_s3),
		.re      (ram_re),
		.raddr_a (a10),
		.raddr_b (a11),
		.rdata_a (h10),
		.rdata_b (h11)
	);

	// stage 4: blend along x
	logic              ok_s4;
	logic [FRAC_W-1:0] fx_s4, fz_s4;
	logic [16:0]       top_c, bot_c;
	logic [FRAC_W:0]   wx;

	assign wx    = inv_weight(fx_s4);
	assign top_c = 17'(h00) * 17'(wx) + 17'(h01) * 17'(fx_s4);
	assign bot_c = 17'(h10) * 17'(wx) + 17'(h11) * 17'(fx_s4);

	// stage 5: blend along z
	logic              ok_s5;
	logic [FRAC_W-1:0] fz_s5;
	logic [16:0]       top_s5, bot_s5;
	logic [23:0]       sum_c;

	assign sum_c = 24'(top_s5) * 24'(inv_weight(fz_s5)) + 24'(bot_s5) * 24'(fz_s5);

	logic [RES_W-1:0] height_q;
	logic             in_range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1)    v_s1        <= s_axis_tvalid;
			if (rdy2)    v_s2        <= v_s1;
			if (rdy3)    v_s3        <= v_s2;
			if (rdy4)    v_s4        <= v_s3 && (op_s3 == OP_QUERY);
			if (rdy5)    v_s5        <= v_s4;
			if (rdy_out) out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_axis_tvalid) begin
			op_s1  <= in_op;
			idx_s1 <= in_idx;
			hgt_s1 <= in_hgt;
			px_s1  <= PROD_W'($signed({in_x[POS_W-1], in_x}) * scale_s);
			pz_s1  <= PROD_W'(neg_z * scale_s);
		end
		if (rdy2 && v_s1) begin
			op_s2  <= op_s1;
			idx_s2 <= idx_s1;
			hgt_s2 <= hgt_s1;
			ok_s2  <= ok_c;
			x0_s2  <= gx[FRAC_W +: XW];
			z0_s2  <= gz[FRAC_W +: ZW];
			fx_s2  <= gx[FRAC_W-1:0];
			fz_s2  <= gz[FRAC_W-1:0];
		end
		if (rdy3 && v_s2) begin
			op_s3  <= op_s2;
			idx_s3 <= idx_s2;
			hgt_s3 <= hgt_s2;
			ok_s3  <= ok_s2;
			x0_s3  <= x0_s2;
			z0_s3  <= z0_s2;
			fx_s3  <= fx_s2;
			fz_s3  <= fz_s2;
		end
		if (ram_re) begin
			ok_s4 <= ok_s3;
			fx_s4 <= fx_s3;
			fz_s4 <= fz_s3;
		end
		if (rdy5 && v_s4) begin
			ok_s5  <= ok_s4;
			fz_s5  <= fz_s4;
			top_s5 <= top_c;
			bot_s5 <= bot_c;
		end
		if (rdy_out && v_s5) begin
			height_q   <= ok_s5 ? sum_c[23:8] : '0;
			in_range_q <= ok_s5;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = height_q;
	assign m_axis_tuser[0] = in_range_q;

	`HBS_ASSERT_NOW(a_no_rw_clash, ram_we, !ram_re, "store read and write in one cycle")
	`HBS_ASSERT_NEXT(a_query_reaches_s4, ram_re, v_s4, "query lost after store read")
	`HBS_ASSERT_NOW(a_oob_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0,
		"out-of-range result carries nonzero height")
	`HBS_ASSERT_NOW(a_stall_has_item, !s_axis_tready, v_s1, "input stalled with empty stage 1")

endmodule

/* bench/tb_heightmap_bilinear_sample.sv */
`timescale 1ns / 1ps

module tb_heightmap_bilinear_sample;
	import hbs_pkg::*;

	localparam int LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam logic [CFG_IW-1:0] REG_NONE = 2'd3;

	typedef struct {
		op_t               op;
		logic [IDX_W-1:0]  idx;
		logic [HGT_W-1:0]  hgt;
		logic [POS_W-1:0]  qx;
		logic [POS_W-1:0]  qz;
	} hmap_item_t;

	typedef struct {
		logic [RES_W-1:0] height;
		logic             in_range;
	} height_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [IN_DW-1:0]    s_axis_tdata = '0;
	logic [0:0]          s_axis_tuser = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [RES_W-1:0]    m_axis_tdata;
	logic [0:0]          m_axis_tuser;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_IW-1:0]   cfg_index = '0;
	logic [SCALE_W-1:0]  cfg_data = '0;

	// predictor state
	logic [HGT_W-1:0]    terrain [STORE_SIZE];
	logic [DIM_W-1:0]    model_w = DIM_RST;
	logic [DIM_W-1:0]    model_d = DIM_RST;
	logic [SCALE_W-1:0]  model_s = SCALE_RST;

	// stimulus side
	bit                  loaded [STORE_SIZE];
	hmap_item_t          sample_items [$];
	hmap_item_t          cur_item;
	height_t             pending_heights [$];
	int                  queued_count = 0;
	int                  accepted_count = 0;
	int                  error_count = 0;
	int                  cycle_count = 0;
	bit                  calm = 1'b0;

	heightmap_bilinear_sample DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		// load_index, load_height, query_x, query_z
		.s_axis_tdata  (s_axis_tdata),
		// op
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		// height
		.m_axis_tdata  (m_axis_tdata),
		// in_range
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned dim_eff(input logic [DIM_W-1:0] v, input int unsigned maxv);
		return (v > maxv) ? maxv : int'(v);
	endfunction

	// world position -> grid Q.8; returns in_range, base is the linear index of corner (x0, z0)
	function automatic bit grid_map(input logic [POS_W-1:0] qx, input logic [POS_W-1:0] qz,
			output longint gx, output longint gz, output int unsigned base);
		int unsigned we, de;
		longint px, pz, lx, lz;
		we = dim_eff(model_w, MAX_WIDTH);
		de = dim_eff(model_d, MAX_DEPTH);
		px = longint'($signed(qx)) * longint'(model_s);
		pz = -longint'($signed(qz)) * longint'(model_s);
		gx = 0;
		gz = 0;
		base = 0;
		if (px < 0 || pz < 0)
			return 1'b0;
		gx = px >>> 16;
		gz = pz >>> 16;
		lx = (we >= 1) ? longint'(we - 1) << 8 : 0;
		lz = (de >= 1) ? longint'(de - 1) << 8 : 0;
		base = int'(gx >> 8) + int'(gz >> 8) * we;
		return (gx < lx) && (gz < lz);
	endfunction

	task automatic sample_terrain(input hmap_item_t it);
		longint gx, gz, sum, fx, fz;
		int unsigned base, we;
		longint h00, h01, h11, h10;
		height_t r;
		if (it.op == OP_LOAD) begin
			terrain[it.idx] = it.hgt;
			return;
		end
		if (!grid_map(it.qx, it.qz, gx, gz, base)) begin
			r.height = '0;
			r.in_range = 1'b0;
		end else begin
			we = dim_eff(model_w, MAX_WIDTH);
			fx = gx & 255;
			fz = gz & 255;
			h00 = terrain[IDX_W'(base)];
			h01 = terrain[IDX_W'(base + 1)];
			h11 = terrain[IDX_W'(base + we + 1)];
			h10 = terrain[IDX_W'(base + we)];
			sum = h00 * (256 - fx) * (256 - fz) + h01 * fx * (256 - fz)
				+ h11 * fx * fz + h10 * (256 - fx) * fz;
			r.height = RES_W'(sum >> 8);
			r.in_range = 1'b1;
		end
		pending_heights.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
	endtask

	// ---- stimulus builders ----
	task automatic add_load(input int unsigned idx, input logic [HGT_W-1:0] h);
		hmap_item_t it;
		it.op = OP_LOAD;
		it.idx = IDX_W'(idx);
		it.hgt = h;
		it.qx = POS_W'($urandom);
		it.qz = POS_W'($urandom);
		loaded[it.idx] = 1'b1;
		sample_items.push_back(it);
		queued_count++;
	endtask

	// corners of an in-range query get loaded first so no unwritten entry is read
	task automatic add_query(input logic [POS_W-1:0] qx, input logic [POS_W-1:0] qz);
		hmap_item_t it;
		longint gx, gz;
		int unsigned base, we;
		int unsigned corner [4];
		if (grid_map(qx, qz, gx, gz, base)) begin
			we = dim_eff(model_w, MAX_WIDTH);
			corner = '{base, base + 1, base + we, base + we + 1};
			foreach (corner[k])
				if (!loaded[IDX_W'(corner[k])])
					add_load(corner[k], HGT_W'($urandom));
		end
		it.op = OP_QUERY;
		it.idx = IDX_W'($urandom);
		it.hgt = HGT_W'($urandom);
		it.qx = qx;
		it.qz = qz;
		sample_items.push_back(it);
		queued_count++;
	endtask

	task automatic add_random(input int n);
		int unsigned we, de, area, r;
		longint lx, lz, gt, q;
		logic [POS_W-1:0] qx, qz;
		int start;
		we = dim_eff(model_w, MAX_WIDTH);
		de = dim_eff(model_d, MAX_DEPTH);
		area = (we * de == 0) ? 1 : we * de;
		lx = (we >= 2) ? longint'(we - 1) << 8 : 1024;
		lz = (de >= 2) ? longint'(de - 1) << 8 : 1024;
		start = queued_count;
		// corner loads count toward n
		while (queued_count - start < n) begin
			r = $urandom_range(99);
			if (r < 15) begin
				if ($urandom_range(1))
					add_load($urandom_range(area - 1), HGT_W'($urandom));
				else
					add_load($urandom, HGT_W'($urandom));
			end else if (r < 85) begin
				// aim at a grid point inside the interior
				gt = $urandom_range(int'(lx - 1));
				q = (model_s == 0) ? longint'($urandom_range(8388607)) : (gt << 16) / model_s;
				if (q > 8388607)
					q = 8388607;
				qx = POS_W'(q);
				gt = $urandom_range(int'(lz - 1));
				q = (model_s == 0) ? longint'($urandom_range(8388608)) : (gt << 16) / model_s;
				if (q > 8388608)
					q = 8388608;
				qz = POS_W'(-q);
				add_query(qx, qz);
			end else begin
				add_query(POS_W'($urandom), POS_W'($urandom));
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] index, input logic [SCALE_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained;
		do
			@(negedge clk);
		while (accepted_count != queued_count || pending_heights.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] d,
			input logic [SCALE_W-1:0] s, input int n, input bit no_idle);
		wait_drained;
		// upper data bits above a dimension are don't-care
		write_reg(REG_GRID_WIDTH, {15'($urandom), w});
		write_reg(REG_GRID_DEPTH, {15'($urandom), d});
		write_reg(REG_INV_SCALE, s);
		@(negedge clk);
		calm = no_idle;
		add_random(n);
	endtask

	// ---- driver ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				sample_terrain(cur_item);
				accepted_count++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (sample_items.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
					cur_item = sample_items.pop_front();
					s_axis_tdata <= {cur_item.qz, cur_item.qx, cur_item.hgt, cur_item.idx};
					s_axis_tuser <= cur_item.op;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---- monitor ----
	always @(posedge clk or negedge arst_n) begin
		height_t e;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(99) >= 31);
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_heights.size() == 0) begin
					report_mismatch("unexpected result, height", m_axis_tdata, -1);
				end else begin
					e = pending_heights.pop_front();
					if (m_axis_tdata !== e.height)
						report_mismatch("height", m_axis_tdata, e.height);
					if (m_axis_tuser[0] !== e.in_range)
						report_mismatch("in_range", m_axis_tuser[0], e.in_range);
				end
			end
		end
	end

	// register shadow, updated on the accepted write
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GRID_WIDTH: model_w <= cfg_data[DIM_W-1:0];
				REG_GRID_DEPTH: model_d <= cfg_data[DIM_W-1:0];
				REG_INV_SCALE:  model_s <= cfg_data;
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("tb_heightmap_bilinear_sample NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset setting: 256 x 256, scale one half, so grid = world / 2
		add_load(0, 8'd255);
		add_load(1, 8'd0);
		add_load(256, 8'd255);
		add_load(257, 8'd128);
		add_load(65535, 8'd255);
		add_load(65534, 8'd0);
		add_query(24'd0, 24'd0);
		add_query(24'd1, -24'sd1);
		add_query(24'd510, -24'sd510);
		add_query(24'd130558, -24'sd130558);   // last interior cell, full fractions
		add_query(24'd130560, 24'd0);          // x exactly on the edge
		add_query(24'd0, -24'sd130560);        // z exactly on the edge
		add_query(24'h7FFFFF, 24'h800000);
		add_query(24'h800000, 24'd0);
		add_query(24'hFFFFFF, 24'd0);          // negative x
		add_query(24'd0, 24'd1);               // positive z is behind the terrain
		add_query(24'd0, 24'h7FFFFF);
		add_random(80);

		run_phase(9'd4, 9'd3, 24'd65536, 150, 1'b0);
		run_phase(9'd2, 9'd2, 24'hFFFFFF, 150, 1'b0);
		run_phase(9'd256, 9'd256, 24'd1, 150, 1'b0);
		// dimensions above the maximum saturate
		run_phase(9'd511, 9'd300, 24'h012345, 150, 1'b0);
		// too small: nothing is in range
		run_phase(9'd1, 9'd0, 24'h00C000, 100, 1'b0);
		// zero scale maps everything onto grid origin
		run_phase(9'd17, 9'd33, 24'd0, 100, 1'b0);
		run_phase(9'($urandom_range(2, 256)), 9'($urandom_range(2, 256)),
			24'($urandom_range(1, 24'hFFFFFF)), 200, 1'b1);

		// an unknown register index must change nothing
		wait_drained;
		write_reg(REG_NONE, 24'($urandom));
		@(negedge clk);
		calm = 1'b0;
		add_random(100);

		run_phase(9'($urandom_range(2, 64)), 9'($urandom_range(2, 64)),
			24'($urandom_range(1, 24'h040000)), 150, 1'b0);

		wait_drained;
		if (error_count == 0)
			$display("tb_heightmap_bilinear_sample OK");
		else
			$display("tb_heightmap_bilinear_sample NOT OK");
		$finish;
	end

endmodule
